>>> hdl/chd_pkg.sv
package chd_pkg;

    localparam int LEN_W    = 14;
    localparam int BUDGET_W = 16;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TRAILERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET  = 2'd1;

    localparam logic [COUNT_W-1:0]  MAX_TRAILERS_RST = 8'd0;
    localparam logic [BUDGET_W-1:0] BYTE_BUDGET_RST  = 16'd4096;

    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SEMI  = 8'h3b;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_HT    = 8'h09;

    typedef enum logic [2:0] {
        ST_BUSY,
        ST_DONE_NOW,
        ST_DONE_BEFORE,
        ST_MALFORMED,
        ST_BUDGET,
        ST_TABLE_FULL,
        ST_FAILED_BEFORE
    } status_t;

    typedef struct packed {
        logic             byte_consumed;
        logic             payload_valid;
        logic [7:0]       payload_byte;
        logic             chunk_end;
        status_t          status;
        logic             need_more;
        logic             trailer_accepted;
        logic [LEN_W-1:0] trailer_name_length;
        logic [LEN_W-1:0] trailer_value_length;
    } res_t;

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_token_char(input logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a)
            || (c >= 8'h61 && c <= 8'h7a)
            || c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25
            || c == 8'h26 || c == 8'h27 || c == 8'h2a || c == 8'h2b
            || c == 8'h2d || c == 8'h2e || c == 8'h5e || c == 8'h5f
            || c == 8'h60 || c == 8'h7c || c == 8'h7e;
        return r;
    endfunction

endpackage

>>> hdl/chd_byte_if.sv
interface chd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_last;

    modport source (output valid, output data_byte, output buffer_last, input ready);
    modport sink (input valid, input data_byte, input buffer_last, output ready);
endinterface

>>> hdl/chd_result_if.sv
interface chd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       byte_consumed;
    logic                       payload_valid;
    logic [7:0]                 payload_byte;
    logic                       chunk_end;
    logic [2:0]                 status;
    logic                       need_more;
    logic                       trailer_accepted;
    logic [chd_pkg::LEN_W-1:0]  trailer_name_length;
    logic [chd_pkg::LEN_W-1:0]  trailer_value_length;

    modport source (
        output valid, input ready,
        output byte_consumed, output payload_valid, output payload_byte,
        output chunk_end, output status, output need_more,
        output trailer_accepted, output trailer_name_length,
        output trailer_value_length
    );
    modport sink (
        input valid, output ready,
        input byte_consumed, input payload_valid, input payload_byte,
        input chunk_end, input status, input need_more,
        input trailer_accepted, input trailer_name_length,
        input trailer_value_length
    );
endinterface

>>> hdl/http_chunked_body_decoder.sv
// A byte passes the input register, then the result register, before its
// result is offered.
// Throughput: one byte per cycle while no result is held by result.ready low.
// Reset (rst_n, async, active low): parser returns to the size line, all
// counters clear, max_trailers = 0, trailer_byte_budget = 4096.
module http_chunked_body_decoder #(
    parameter int MAX_SIZE_DIGITS = 16,
    parameter int MAX_LINE_BYTES  = 8192
) (
    input  logic                                clk,
    input  logic                                rst_n,
    chd_byte_if.sink                            body,
    chd_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [chd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [chd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic                           in_valid_reg;
    logic [7:0]                     in_data_reg;
    logic                           in_last_reg;
    logic                           out_valid_reg;
    chd_pkg::res_t                  out_reg;
    chd_pkg::res_t                  step_res;
    logic                           advance;
    logic [chd_pkg::COUNT_W-1:0]    max_trailers_reg;
    logic [chd_pkg::BUDGET_W-1:0]   byte_budget_reg;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_trailers_reg <= chd_pkg::MAX_TRAILERS_RST;
            byte_budget_reg  <= chd_pkg::BYTE_BUDGET_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == chd_pkg::CFG_MAX_TRAILERS)
            begin
                max_trailers_reg <= cfg_data[chd_pkg::COUNT_W-1:0];
            end
            else if (cfg_index == chd_pkg::CFG_BYTE_BUDGET)
            begin
                byte_budget_reg <= cfg_data[chd_pkg::BUDGET_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (body.ready)
        begin
            in_valid_reg <= body.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (body.valid && body.ready)
        begin
            in_data_reg <= body.data_byte;
            in_last_reg <= body.buffer_last;
        end
    end

    chd_core #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS),
        .MAX_LINE_BYTES  (MAX_LINE_BYTES)
    ) u_core (
        .clk                 (clk),
        .rst_n               (rst_n),
        .step_en             (advance),
        .data_byte           (in_data_reg),
        .buffer_last         (in_last_reg),
        .max_trailers        (max_trailers_reg),
        .trailer_byte_budget (byte_budget_reg),
        .res                 (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.byte_consumed        = out_reg.byte_consumed;
    assign result.payload_valid        = out_reg.payload_valid;
    assign result.payload_byte         = out_reg.payload_byte;
    assign result.chunk_end            = out_reg.chunk_end;
    assign result.status               = out_reg.status;
    assign result.need_more            = out_reg.need_more;
    assign result.trailer_accepted     = out_reg.trailer_accepted;
    assign result.trailer_name_length  = out_reg.trailer_name_length;
    assign result.trailer_value_length = out_reg.trailer_value_length;

`ifndef ASSERT_OFF
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (step_res.status == chd_pkg::ST_MALFORMED
                    || step_res.status == chd_pkg::ST_BUDGET
                    || step_res.status == chd_pkg::ST_TABLE_FULL)
        ##1 advance |-> step_res.status == chd_pkg::ST_FAILED_BEFORE)
        else $error("failure not sticky");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.status == chd_pkg::ST_DONE_NOW
        ##1 advance |-> step_res.status == chd_pkg::ST_DONE_BEFORE
                        && !step_res.byte_consumed)
        else $error("completion not sticky");

    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.payload_valid || result.trailer_accepted)
        |-> result.byte_consumed && result.status == chd_pkg::ST_BUSY)
        else $error("payload or trailer on a non-busy result");
`endif

endmodule

>>> hdl/chd_core.sv
module chd_core #(
    parameter int MAX_SIZE_DIGITS = 16,
    parameter int MAX_LINE_BYTES  = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step_en,
    input  logic [7:0]                      data_byte,
    input  logic                            buffer_last,
    input  logic [chd_pkg::COUNT_W-1:0]     max_trailers,
    input  logic [chd_pkg::BUDGET_W-1:0]    trailer_byte_budget,
    output chd_pkg::res_t                   res
);

    localparam int AccW  = 4 * MAX_SIZE_DIGITS;
    localparam int DigW  = $clog2(MAX_SIZE_DIGITS + 1);
    localparam int LineW = $clog2(MAX_LINE_BYTES + 1);
    localparam int LenW  = chd_pkg::LEN_W;
    localparam int BudW  = chd_pkg::BUDGET_W;
    localparam int CntW  = chd_pkg::COUNT_W;
    localparam int SumW  = BudW + 2;

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_DATA,
        PH_CR,
        PH_LF,
        PH_TRAILER,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [AccW-1:0]    chunk_rem_reg, chunk_rem_next;
    logic [AccW-1:0]    size_acc_reg, size_acc_next;
    logic [DigW-1:0]    digit_cnt_reg, digit_cnt_next;
    logic               in_ext_reg, in_ext_next;
    logic [LineW-1:0]   line_len_reg, line_len_next;
    logic               colon_seen_reg, colon_seen_next;
    logic [LineW-1:0]   name_len_reg, name_len_next;
    logic               name_bad_reg, name_bad_next;
    logic [LineW-1:0]   val_first_reg, val_first_next;
    logic [LineW-1:0]   val_end_reg, val_end_next;
    logic               val_seen_reg, val_seen_next;
    logic [BudW-1:0]    budget_used_reg, budget_used_next;
    logic [CntW-1:0]    trl_cnt_reg, trl_cnt_next;

    logic [4:0]         hex;
    logic [AccW-1:0]    rem_dec;
    logic [LineW-1:0]   val_len;
    logic [SumW-1:0]    need;
    logic [SumW-1:0]    total;
    chd_pkg::status_t   status;

    assign hex     = chd_pkg::hex_digit(data_byte);
    assign rem_dec = (chunk_rem_reg != '0) ? chunk_rem_reg - AccW'(1) : chunk_rem_reg;
    assign val_len = val_seen_reg ? val_end_reg - val_first_reg : '0;
    assign need    = SumW'(name_len_reg) + SumW'(val_len);
    assign total   = need + SumW'(budget_used_reg);

    always_comb
    begin
        phase_next       = phase_reg;
        chunk_rem_next   = chunk_rem_reg;
        size_acc_next    = size_acc_reg;
        digit_cnt_next   = digit_cnt_reg;
        in_ext_next      = in_ext_reg;
        line_len_next    = line_len_reg;
        colon_seen_next  = colon_seen_reg;
        name_len_next    = name_len_reg;
        name_bad_next    = name_bad_reg;
        val_first_next   = val_first_reg;
        val_end_next     = val_end_reg;
        val_seen_next    = val_seen_reg;
        budget_used_next = budget_used_reg;
        trl_cnt_next     = trl_cnt_reg;

        status                   = chd_pkg::ST_BUSY;
        res.byte_consumed        = 1'b1;
        res.payload_valid        = 1'b0;
        res.payload_byte         = 8'd0;
        res.chunk_end            = 1'b0;
        res.trailer_accepted     = 1'b0;
        res.trailer_name_length  = '0;
        res.trailer_value_length = '0;

        unique case (phase_reg)
            PH_DONE:
            begin
                res.byte_consumed = 1'b0;
                status = chd_pkg::ST_DONE_BEFORE;
            end
            PH_FAIL:
            begin
                res.byte_consumed = 1'b0;
                status = chd_pkg::ST_FAILED_BEFORE;
            end
            PH_SIZE:
            begin
                priority if (data_byte == chd_pkg::CHAR_CR)
                begin
                end
                else if (data_byte == chd_pkg::CHAR_LF)
                begin
                    if (digit_cnt_reg == '0)
                    begin
                        status = chd_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        chunk_rem_next  = size_acc_reg;
                        phase_next      = (size_acc_reg == '0) ? PH_TRAILER : PH_DATA;
                        size_acc_next   = '0;
                        digit_cnt_next  = '0;
                        in_ext_next     = 1'b0;
                        line_len_next   = '0;
                        colon_seen_next = 1'b0;
                        name_len_next   = '0;
                        name_bad_next   = 1'b0;
                        val_first_next  = '0;
                        val_end_next    = '0;
                        val_seen_next   = 1'b0;
                    end
                end
                else if (in_ext_reg)
                begin
                end
                else if (data_byte == chd_pkg::CHAR_SEMI)
                begin
                    if (digit_cnt_reg == '0)
                    begin
                        status = chd_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        in_ext_next = 1'b1;
                    end
                end
                else if (!hex[4] || digit_cnt_reg >= DigW'(MAX_SIZE_DIGITS))
                begin
                    status = chd_pkg::ST_MALFORMED;
                end
                else
                begin
                    size_acc_next  = (size_acc_reg << 4) | AccW'(hex[3:0]);
                    digit_cnt_next = digit_cnt_reg + DigW'(1);
                end
            end
            PH_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = data_byte;
                chunk_rem_next    = rem_dec;
                if (rem_dec == '0)
                begin
                    res.chunk_end = 1'b1;
                    phase_next    = PH_CR;
                end
            end
            PH_CR:
            begin
                if (data_byte != chd_pkg::CHAR_CR)
                begin
                    status = chd_pkg::ST_MALFORMED;
                end
                else
                begin
                    phase_next = PH_LF;
                end
            end
            PH_LF:
            begin
                if (data_byte != chd_pkg::CHAR_LF)
                begin
                    status = chd_pkg::ST_MALFORMED;
                end
                else
                begin
                    phase_next     = PH_SIZE;
                    size_acc_next  = '0;
                    digit_cnt_next = '0;
                    in_ext_next    = 1'b0;
                end
            end
            PH_TRAILER:
            begin
                priority if (data_byte == chd_pkg::CHAR_LF)
                begin
                    priority if (line_len_reg == '0)
                    begin
                        phase_next = PH_DONE;
                        status     = chd_pkg::ST_DONE_NOW;
                    end
                    else if (!colon_seen_reg || name_len_reg == '0 || name_bad_reg)
                    begin
                        status = chd_pkg::ST_MALFORMED;
                    end
                    else if (total > SumW'(trailer_byte_budget))
                    begin
                        status = chd_pkg::ST_BUDGET;
                    end
                    else if (trl_cnt_reg >= max_trailers)
                    begin
                        status = chd_pkg::ST_TABLE_FULL;
                    end
                    else
                    begin
                        budget_used_next         = total[BudW-1:0];
                        trl_cnt_next             = trl_cnt_reg + CntW'(1);
                        res.trailer_accepted     = 1'b1;
                        res.trailer_name_length  = LenW'(name_len_reg);
                        res.trailer_value_length = LenW'(val_len);
                        line_len_next   = '0;
                        colon_seen_next = 1'b0;
                        name_len_next   = '0;
                        name_bad_next   = 1'b0;
                        val_first_next  = '0;
                        val_end_next    = '0;
                        val_seen_next   = 1'b0;
                    end
                end
                else if (data_byte == chd_pkg::CHAR_CR)
                begin
                end
                else if (line_len_reg >= LineW'(MAX_LINE_BYTES))
                begin
                    status = chd_pkg::ST_MALFORMED;
                end
                else
                begin
                    if (!colon_seen_reg)
                    begin
                        if (data_byte == chd_pkg::CHAR_COLON)
                        begin
                            colon_seen_next = 1'b1;
                            name_len_next   = line_len_reg;
                        end
                        else if (!chd_pkg::is_token_char(data_byte))
                        begin
                            name_bad_next = 1'b1;
                        end
                    end
                    else if (data_byte != chd_pkg::CHAR_SP && data_byte != chd_pkg::CHAR_HT)
                    begin
                        if (!val_seen_reg)
                        begin
                            val_first_next = line_len_reg;
                            val_seen_next  = 1'b1;
                        end
                        val_end_next = line_len_reg + LineW'(1);
                    end
                    line_len_next = line_len_reg + LineW'(1);
                end
            end
            default:
            begin
                res.byte_consumed = 1'b0;
                status     = chd_pkg::ST_FAILED_BEFORE;
                phase_next = PH_FAIL;
            end
        endcase

        if (status == chd_pkg::ST_MALFORMED || status == chd_pkg::ST_BUDGET
            || status == chd_pkg::ST_TABLE_FULL)
        begin
            phase_next = PH_FAIL;
        end

        res.status    = status;
        res.need_more = buffer_last && phase_next != PH_DONE && phase_next != PH_FAIL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SIZE;
            chunk_rem_reg   <= '0;
            size_acc_reg    <= '0;
            digit_cnt_reg   <= '0;
            in_ext_reg      <= 1'b0;
            line_len_reg    <= '0;
            colon_seen_reg  <= 1'b0;
            name_len_reg    <= '0;
            name_bad_reg    <= 1'b0;
            val_first_reg   <= '0;
            val_end_reg     <= '0;
            val_seen_reg    <= 1'b0;
            budget_used_reg <= '0;
            trl_cnt_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            chunk_rem_reg   <= chunk_rem_next;
            size_acc_reg    <= size_acc_next;
            digit_cnt_reg   <= digit_cnt_next;
            in_ext_reg      <= in_ext_next;
            line_len_reg    <= line_len_next;
            colon_seen_reg  <= colon_seen_next;
            name_len_reg    <= name_len_next;
            name_bad_reg    <= name_bad_next;
            val_first_reg   <= val_first_next;
            val_end_reg     <= val_end_next;
            val_seen_reg    <= val_seen_next;
            budget_used_reg <= budget_used_next;
            trl_cnt_reg     <= trl_cnt_next;
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SIZE_DIGITS = 16;
    localparam int LINE_BYTES  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int QUIET_FROM  = 150;
    localparam int QUIET_TO    = 260;
    localparam int LEN_W       = chd_pkg::LEN_W;

    typedef enum logic [2:0] {
        AT_SIZE_LINE,
        AT_DATA,
        AT_DATA_CR,
        AT_DATA_LF,
        AT_TRAILERS,
        AT_COMPLETE,
        AT_FAILED
    } parse_phase_t;

    typedef enum {
        END_CLEAN,
        END_BAD_TRAILER,
        END_BUDGET,
        END_TABLE_FULL,
        END_LONG_LINE,
        END_BAD_SIZE,
        END_BAD_CRLF
    } ending_t;

    class chunked_parse_state;
        chd_pkg::res_t upcoming[$];
        int            errors;
        logic [7:0]    trailer_limit;
        logic [15:0]   byte_budget;
        parse_phase_t  ph;
        logic [63:0]   remaining;
        logic [63:0]   size_acc;
        int            digits;
        bit            in_ext;
        int            line_len;
        bit            colon;
        int            name_len;
        bit            name_bad;
        int            value_first;
        int            value_end;
        bit            value_seen;
        int            used;
        int            count;

        function new();
            errors = 0;
            trailer_limit = chd_pkg::MAX_TRAILERS_RST;
            byte_budget = chd_pkg::BYTE_BUDGET_RST;
            ph = AT_SIZE_LINE;
            remaining = '0;
            used = 0;
            count = 0;
            clear_size();
            clear_line();
        endfunction

        function void clear_size();
            size_acc = '0;
            digits = 0;
            in_ext = 1'b0;
        endfunction

        function void clear_line();
            line_len = 0;
            colon = 1'b0;
            name_len = 0;
            name_bad = 1'b0;
            value_first = 0;
            value_end = 0;
            value_seen = 1'b0;
        endfunction

        function bit stopped();
            return ph == AT_COMPLETE || ph == AT_FAILED;
        endfunction

        function void set_register(logic [chd_pkg::CFG_IDX_W-1:0] idx,
                                   logic [chd_pkg::CFG_DATA_W-1:0] val);
            if (idx == chd_pkg::CFG_MAX_TRAILERS)
            begin
                trailer_limit = val[7:0];
            end
            else if (idx == chd_pkg::CFG_BYTE_BUDGET)
            begin
                byte_budget = val;
            end
        endfunction

        function void absorb_byte(logic [7:0] c, logic last);
            chd_pkg::res_t r;
            logic [3:0]    nib;
            bit            is_hex;
            bit            tok;
            int            nlen;
            int            vlen;
            int            need;
            r = '0;
            r.byte_consumed = 1'b1;
            r.status = chd_pkg::ST_BUSY;
            nib = 4'd0;
            case (ph)
                AT_COMPLETE:
                begin
                    r.byte_consumed = 1'b0;
                    r.status = chd_pkg::ST_DONE_BEFORE;
                end
                AT_FAILED:
                begin
                    r.byte_consumed = 1'b0;
                    r.status = chd_pkg::ST_FAILED_BEFORE;
                end
                AT_SIZE_LINE:
                begin
                    if (c == chd_pkg::CHAR_LF)
                    begin
                        if (digits == 0)
                        begin
                            r.status = chd_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            remaining = size_acc;
                            ph = (remaining == 64'd0) ? AT_TRAILERS : AT_DATA;
                            clear_size();
                            clear_line();
                        end
                    end
                    else if (c != chd_pkg::CHAR_CR && !in_ext)
                    begin
                        if (c == chd_pkg::CHAR_SEMI)
                        begin
                            if (digits == 0)
                            begin
                                r.status = chd_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                in_ext = 1'b1;
                            end
                        end
                        else
                        begin
                            is_hex = 1'b1;
                            if (c >= "0" && c <= "9")
                            begin
                                nib = 4'(c - 8'h30);
                            end
                            else if (c >= "a" && c <= "f")
                            begin
                                nib = 4'(c - 8'h57);
                            end
                            else if (c >= "A" && c <= "F")
                            begin
                                nib = 4'(c - 8'h37);
                            end
                            else
                            begin
                                is_hex = 1'b0;
                            end
                            if (!is_hex || digits >= SIZE_DIGITS)
                            begin
                                r.status = chd_pkg::ST_MALFORMED;
                            end
                            else
                            begin
                                size_acc = {size_acc[59:0], nib};
                                digits++;
                            end
                        end
                    end
                end
                AT_DATA:
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = c;
                    if (remaining != 64'd0)
                    begin
                        remaining = remaining - 64'd1;
                    end
                    if (remaining == 64'd0)
                    begin
                        r.chunk_end = 1'b1;
                        ph = AT_DATA_CR;
                    end
                end
                AT_DATA_CR:
                begin
                    if (c != chd_pkg::CHAR_CR)
                    begin
                        r.status = chd_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        ph = AT_DATA_LF;
                    end
                end
                AT_DATA_LF:
                begin
                    if (c != chd_pkg::CHAR_LF)
                    begin
                        r.status = chd_pkg::ST_MALFORMED;
                    end
                    else
                    begin
                        ph = AT_SIZE_LINE;
                        clear_size();
                    end
                end
                default:
                begin
                    if (c == chd_pkg::CHAR_LF)
                    begin
                        if (line_len == 0)
                        begin
                            ph = AT_COMPLETE;
                            r.status = chd_pkg::ST_DONE_NOW;
                        end
                        else if (!colon || name_len == 0 || name_bad)
                        begin
                            r.status = chd_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            nlen = name_len;
                            vlen = value_seen ? (value_end - value_first) : 0;
                            need = nlen + vlen;
                            if (need + used > int'(byte_budget))
                            begin
                                r.status = chd_pkg::ST_BUDGET;
                            end
                            else if (count >= int'(trailer_limit))
                            begin
                                r.status = chd_pkg::ST_TABLE_FULL;
                            end
                            else
                            begin
                                used = (used + need) & 32'hFFFF;
                                count = (count + 1) & 32'hFF;
                                r.trailer_accepted = 1'b1;
                                r.trailer_name_length = LEN_W'(nlen);
                                r.trailer_value_length = LEN_W'(vlen);
                                clear_line();
                            end
                        end
                    end
                    else if (c != chd_pkg::CHAR_CR)
                    begin
                        if (line_len >= LINE_BYTES)
                        begin
                            r.status = chd_pkg::ST_MALFORMED;
                        end
                        else
                        begin
                            if (!colon)
                            begin
                                tok = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z")
                                    || (c >= "a" && c <= "z") || c == 8'h60;
                                case (c)
                                    "!", "#", "$", "%", "&", "'", "*", "+", "-", ".",
                                    "^", "_", "|", "~": tok = 1'b1;
                                    default: ;
                                endcase
                                if (c == chd_pkg::CHAR_COLON)
                                begin
                                    colon = 1'b1;
                                    name_len = line_len;
                                end
                                else if (!tok)
                                begin
                                    name_bad = 1'b1;
                                end
                            end
                            else if (c != chd_pkg::CHAR_SP && c != chd_pkg::CHAR_HT)
                            begin
                                if (!value_seen)
                                begin
                                    value_first = line_len;
                                    value_seen = 1'b1;
                                end
                                value_end = line_len + 1;
                            end
                            line_len++;
                        end
                    end
                end
            endcase
            if (r.status == chd_pkg::ST_MALFORMED || r.status == chd_pkg::ST_BUDGET
                || r.status == chd_pkg::ST_TABLE_FULL)
            begin
                ph = AT_FAILED;
            end
            r.need_more = last && ph != AT_COMPLETE && ph != AT_FAILED;
            upcoming.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, seen);
                errors++;
            end
        endfunction

        function void match_result(chd_pkg::res_t got);
            chd_pkg::res_t want;
            if (upcoming.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, got);
                errors++;
            end
            else
            begin
                want = upcoming.pop_front();
                compare_field("byte_consumed", 16'(want.byte_consumed), 16'(got.byte_consumed));
                compare_field("payload_valid", 16'(want.payload_valid), 16'(got.payload_valid));
                compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
                compare_field("chunk_end", 16'(want.chunk_end), 16'(got.chunk_end));
                compare_field("status", 16'(want.status), 16'(got.status));
                compare_field("need_more", 16'(want.need_more), 16'(got.need_more));
                compare_field("trailer_accepted", 16'(want.trailer_accepted),
                              16'(got.trailer_accepted));
                compare_field("trailer_name_length", 16'(want.trailer_name_length),
                              16'(got.trailer_name_length));
                compare_field("trailer_value_length", 16'(want.trailer_value_length),
                              16'(got.trailer_value_length));
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [chd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [chd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           sink_ready = 1'b0;
    bit                             quiet = 1'b0;
    int                             sent_count = 0;
    int                             cycle_count = 0;
    string                          token_set =
        "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
    chunked_parse_state             parse = new();
    chd_pkg::res_t                  observed;

    chd_byte_if   body_ch();
    chd_result_if result_ch();

    assign result_ch.ready = sink_ready;

    http_chunked_body_decoder #(
        .MAX_SIZE_DIGITS(SIZE_DIGITS),
        .MAX_LINE_BYTES(LINE_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .body(body_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        sink_ready <= quiet || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            observed.byte_consumed = result_ch.byte_consumed;
            observed.payload_valid = result_ch.payload_valid;
            observed.payload_byte = result_ch.payload_byte;
            observed.chunk_end = result_ch.chunk_end;
            observed.status = chd_pkg::status_t'(result_ch.status);
            observed.need_more = result_ch.need_more;
            observed.trailer_accepted = result_ch.trailer_accepted;
            observed.trailer_name_length = result_ch.trailer_name_length;
            observed.trailer_value_length = result_ch.trailer_value_length;
            parse.match_result(observed);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] base;
        if (v < 4'd10)
        begin
            return 8'h30 + 8'(v);
        end
        base = ($urandom_range(0, 1) == 1) ? "A" : "a";
        return base + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b == chd_pkg::CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] token_char();
        return token_set[$urandom_range(0, token_set.len() - 1)];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        logic last;
        last = ($urandom_range(0, 7) == 0);
        quiet = (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
        while (!quiet && $urandom_range(0, 99) < 19)
        begin
            body_ch.valid <= 1'b0;
            @(posedge clk);
        end
        body_ch.valid <= 1'b1;
        body_ch.data_byte <= b;
        body_ch.buffer_last <= last;
        @(posedge clk);
        while (!body_ch.ready)
        begin
            @(posedge clk);
        end
        parse.absorb_byte(b, last);
        sent_count++;
    endtask

    task automatic write_register(input logic [chd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [chd_pkg::CFG_DATA_W-1:0] val);
        body_ch.valid <= 1'b0;
        @(posedge clk);
        while (parse.upcoming.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        parse.set_register(idx, val);
    endtask

    task automatic send_size_line(input logic [63:0] value, input int digits,
                                  input bit with_ext);
        int k;
        for (k = digits - 1; k >= 0; k--)
        begin
            send_byte(hex_char(value[k*4 +: 4]));
        end
        if (with_ext)
        begin
            send_byte(chd_pkg::CHAR_SEMI);
            repeat ($urandom_range(0, 6)) send_byte(any_but_lf());
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_byte(chd_pkg::CHAR_CR);
        end
        send_byte(chd_pkg::CHAR_LF);
    endtask

    task automatic send_chunk(input int size, input bit break_crlf);
        int         digits;
        int         k;
        logic [7:0] b;
        digits = 1;
        while ((size >> (4 * digits)) != 0)
        begin
            digits++;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            digits = $urandom_range(digits, SIZE_DIGITS);
        end
        send_size_line(64'(size), digits, $urandom_range(0, 3) == 0);
        for (k = 0; k < size; k++)
        begin
            send_byte(8'($urandom));
        end
        if (break_crlf && $urandom_range(0, 1) == 0)
        begin
            do
            begin
                b = 8'($urandom);
            end
            while (b == chd_pkg::CHAR_CR);
            send_byte(b);
        end
        else
        begin
            send_byte(chd_pkg::CHAR_CR);
            if (break_crlf)
            begin
                do
                begin
                    b = 8'($urandom);
                end
                while (b == chd_pkg::CHAR_LF);
                send_byte(b);
            end
            else
            begin
                send_byte(chd_pkg::CHAR_LF);
            end
        end
    endtask

    task automatic send_trailer(input int name_len, input int value_len);
        int k;
        for (k = 0; k < name_len; k++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_byte(chd_pkg::CHAR_CR);
            end
            send_byte(token_char());
        end
        send_byte(chd_pkg::CHAR_COLON);
        repeat ($urandom_range(0, 2))
            send_byte($urandom_range(0, 1) ? chd_pkg::CHAR_SP : chd_pkg::CHAR_HT);
        for (k = 0; k < value_len; k++)
        begin
            send_byte(($urandom_range(0, 3) == 0) ? any_but_lf()
                                                  : 8'($urandom_range(8'h21, 8'h7e)));
        end
        repeat ($urandom_range(0, 2))
            send_byte($urandom_range(0, 1) ? chd_pkg::CHAR_SP : chd_pkg::CHAR_HT);
        if ($urandom_range(0, 1) == 1)
        begin
            send_byte(chd_pkg::CHAR_CR);
        end
        send_byte(chd_pkg::CHAR_LF);
    endtask

    initial
    begin
        int         size;
        int         n_trailers;
        int         k;
        int         chunk_count;
        ending_t    ending;
        logic [7:0] b;
        logic [4:0] hv;
        body_ch.valid = 1'b0;
        body_ch.data_byte = 8'd0;
        body_ch.buffer_last = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(chd_pkg::CFG_MAX_TRAILERS, 16'd255);
        write_register(chd_pkg::CFG_BYTE_BUDGET, 16'hFFFF);

        // one-byte chunk with an extension, then a size with all leading zeros
        send_byte("1");
        send_byte(chd_pkg::CHAR_SEMI);
        send_byte(8'hFF);
        send_byte(chd_pkg::CHAR_CR);
        send_byte(chd_pkg::CHAR_LF);
        send_byte(8'hFF);
        send_byte(chd_pkg::CHAR_CR);
        send_byte(chd_pkg::CHAR_LF);
        send_size_line(64'd2, SIZE_DIGITS, 1'b0);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(chd_pkg::CHAR_CR);
        send_byte(chd_pkg::CHAR_LF);

        chunk_count = 0;
        while (sent_count < 360)
        begin
            if (chunk_count % 7 == 6)
            begin
                write_register(chd_pkg::CFG_MAX_TRAILERS, 16'($urandom_range(0, 255)));
                write_register(chd_pkg::CFG_BYTE_BUDGET,
                               ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
            end
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 24);
            send_chunk(size, 1'b0);
            chunk_count++;
        end

        case ($urandom_range(0, 11))
            5: ending = END_BAD_TRAILER;
            6: ending = END_BUDGET;
            7: ending = END_TABLE_FULL;
            8: ending = END_LONG_LINE;
            9, 10: ending = END_BAD_SIZE;
            11: ending = END_BAD_CRLF;
            default: ending = END_CLEAN;
        endcase
        n_trailers = $urandom_range(0, 12);

        if (ending == END_BAD_SIZE)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    do
                    begin
                        b = 8'($urandom);
                        hv = chd_pkg::hex_digit(b);
                    end
                    while (hv[4] || b == chd_pkg::CHAR_CR || b == chd_pkg::CHAR_LF
                           || b == chd_pkg::CHAR_SEMI);
                    send_byte(b);
                end
                1: send_byte(chd_pkg::CHAR_SEMI);
                2: repeat (SIZE_DIGITS + 1) send_byte(hex_char(4'($urandom)));
                default: send_byte(chd_pkg::CHAR_LF);
            endcase
        end
        else if (ending == END_BAD_CRLF)
        begin
            send_chunk($urandom_range(1, 8), 1'b1);
        end
        else
        begin
            send_size_line(64'd0, $urandom_range(1, 3), $urandom_range(0, 1) == 1);
            case (ending)
                END_CLEAN:
                begin
                    write_register(chd_pkg::CFG_MAX_TRAILERS,
                                   ($urandom_range(0, 2) == 0) ? 16'd255
                                       : 16'($urandom_range(n_trailers, 255)));
                    write_register(chd_pkg::CFG_BYTE_BUDGET,
                                   ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                       : 16'($urandom_range(1000, 65535)));
                    for (k = 0; k < n_trailers; k++)
                    begin
                        send_trailer($urandom_range(1, 10), $urandom_range(0, 16));
                    end
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_byte(chd_pkg::CHAR_CR);
                    end
                    send_byte(chd_pkg::CHAR_LF);
                end
                END_TABLE_FULL:
                begin
                    write_register(chd_pkg::CFG_MAX_TRAILERS, 16'(n_trailers));
                    write_register(chd_pkg::CFG_BYTE_BUDGET, 16'hFFFF);
                    for (k = 0; k <= n_trailers; k++)
                    begin
                        send_trailer($urandom_range(1, 10), $urandom_range(0, 16));
                    end
                end
                END_BUDGET:
                begin
                    write_register(chd_pkg::CFG_MAX_TRAILERS, 16'd255);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        write_register(chd_pkg::CFG_BYTE_BUDGET, 16'($urandom_range(0, 80)));
                    end
                    else
                    begin
                        // lowered below what the accepted trailers already hold
                        write_register(chd_pkg::CFG_BYTE_BUDGET, 16'hFFFF);
                        for (k = 0; k < n_trailers + 1; k++)
                        begin
                            send_trailer($urandom_range(1, 10), $urandom_range(0, 16));
                        end
                        write_register(chd_pkg::CFG_BYTE_BUDGET,
                                       16'($urandom_range(0, parse.used - 1)));
                    end
                    k = 0;
                    while (!parse.stopped() && k < 60)
                    begin
                        send_trailer($urandom_range(1, 10), $urandom_range(0, 16));
                        k++;
                    end
                end
                END_LONG_LINE:
                begin
                    write_register(chd_pkg::CFG_MAX_TRAILERS, 16'd255);
                    send_byte("a");
                    send_byte(chd_pkg::CHAR_COLON);
                    while (!parse.stopped())
                    begin
                        send_byte(any_but_lf());
                    end
                end
                default:
                begin
                    write_register(chd_pkg::CFG_MAX_TRAILERS, 16'd255);
                    write_register(chd_pkg::CFG_BYTE_BUDGET, 16'hFFFF);
                    for (k = 0; k < n_trailers; k++)
                    begin
                        send_trailer($urandom_range(1, 10), $urandom_range(0, 16));
                    end
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            repeat ($urandom_range(1, 5)) send_byte(token_char());
                        end
                        1:
                        begin
                            send_byte(chd_pkg::CHAR_COLON);
                            repeat ($urandom_range(0, 5)) send_byte(token_char());
                        end
                        default:
                        begin
                            repeat ($urandom_range(0, 3)) send_byte(token_char());
                            do
                            begin
                                b = 8'($urandom);
                            end
                            while (chd_pkg::is_token_char(b) || b == chd_pkg::CHAR_COLON
                                   || b == chd_pkg::CHAR_CR || b == chd_pkg::CHAR_LF);
                            send_byte(b);
                            repeat ($urandom_range(0, 3)) send_byte(token_char());
                            send_byte(chd_pkg::CHAR_COLON);
                            repeat ($urandom_range(0, 5)) send_byte(token_char());
                        end
                    endcase
                    send_byte(chd_pkg::CHAR_LF);
                end
            endcase
        end

        // body is over: these must come back unconsumed
        repeat (12) send_byte(8'($urandom));

        body_ch.valid <= 1'b0;
        while (parse.upcoming.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (parse.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
